@@ design/mhds_pkg.sv @@
// Package for the median Hamming descriptor selector.
// Holds the shared sizes and the popcount helper; no dependencies.
package mhds_pkg;
    localparam int MaxObs    = 32;
    localparam int IdxW      = $clog2(MaxObs);
    localparam int CntW      = $clog2(MaxObs + 1);
    localparam int DistW     = 9;
    localparam int DescW     = 256;
    localparam int OutIdxW   = 5;

    // popcount of a 64-bit value, result 0..64; pairwise adder tree
    function automatic logic [6:0] pop64(input logic [63:0] v);
        logic [63:0] s;
        s = v - ((v >> 1) & 64'h5555_5555_5555_5555);
        s = (s & 64'h3333_3333_3333_3333) + ((s >> 2) & 64'h3333_3333_3333_3333);
        s = (s + (s >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
        // fold byte counts; every partial sum stays below 256
        s = s + (s >> 8);
        s = s + (s >> 16);
        s = s + (s >> 32);
        return s[6:0];
    endfunction
endpackage

@@ design/mhds_if.sv @@
// Valid/ready channel interface for the selector.
// Depends on nothing; the payload is a generic packed vector.
interface mhds_if #(parameter int W = 1) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/mhds_ram.sv @@
// Generic single-port-write, single-read synchronous RAM.
// Registered read: data for an address comes out in the next cycle; no dependencies.
module mhds_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/median_hamming_descriptor_select.sv @@
// Median Hamming descriptor selector, top level.
// Load: one descriptor word accepted per cycle, back to back. After the last word:
// distances for every (i,j) pair (row read, column read, distance write per pair), then
// a row scan per median candidate, 1..N candidates per row, then the best descriptor
// is fetched and presented; no new set until it is taken.
// Reset (synchronous, active low) clears count, overflow flag, state, sub-step and out valid.
module median_hamming_descriptor_select
    import mhds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mhds_if.sink       s_in,
    mhds_if.source     m_out
);
    typedef enum logic [2:0] {
        S_LOAD, S_DA, S_DB, S_DW, S_MED, S_FETCH, S_FW, S_OUT
    } t_state;

    t_state            r_state;
    logic [CntW-1:0]   r_cnt;
    logic              r_ovf;
    logic [IdxW-1:0]   r_i, r_j, r_k;
    logic [DescW-1:0]  r_da;
    logic [DistW-1:0]  r_cand;      // candidate median value of row i (element k)
    logic [CntW-1:0]   r_less, r_leq;
    logic [DistW-1:0]  r_best_med;
    logic [IdxW-1:0]   r_best;
    logic [1:0]        r_sub;       // 0/1: read cand, 2/3: scan

    // descriptor memory
    logic              d_we;
    logic [IdxW-1:0]   d_waddr, d_raddr;
    logic [DescW-1:0]  d_rdata;
    // distance memory
    logic              t_we;
    logic [2*IdxW-1:0] t_waddr, t_raddr;
    logic [DistW-1:0]  t_wdata, t_rdata;

    mhds_ram #(.Width(DescW), .Depth(MaxObs)) u_desc (
        .i_clk, .i_we(d_we), .i_waddr(d_waddr), .i_wdata(s_in.data[DescW-1:0]),
        .i_raddr(d_raddr), .o_rdata(d_rdata));
    mhds_ram #(.Width(DistW), .Depth(MaxObs*MaxObs)) u_dist (
        .i_clk, .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata));

    logic        acc;
    logic        last;
    logic [IdxW-1:0] nm1;
    logic [CntW-1:0] half;
    logic [DescW-1:0] x;
    logic [DistW-1:0] hd;

    assign s_in.ready = (r_state == S_LOAD);
    assign acc  = s_in.valid && s_in.ready;
    assign last = s_in.data[DescW];
    assign d_we    = acc && (r_cnt < CntW'(MaxObs));
    assign d_waddr = r_cnt[IdxW-1:0];
    assign nm1     = IdxW'(r_cnt - 1'b1);
    assign half    = (r_cnt - 1'b1) >> 1;

    always_comb begin
        x  = r_da ^ d_rdata;
        hd = DistW'(pop64(x[63:0])) + DistW'(pop64(x[127:64]))
           + DistW'(pop64(x[191:128])) + DistW'(pop64(x[255:192]));
    end

    // descriptor read address: row i in S_DA, column j in S_DB, best at output
    always_comb begin
        d_raddr = r_i;
        if (r_state == S_DB) d_raddr = r_j;
        if (r_state == S_FETCH) d_raddr = r_best;
    end
    assign t_we    = (r_state == S_DW);
    assign t_waddr = {r_i, r_j};
    assign t_wdata = (r_i == r_j) ? '0 : hd;
    // candidate read at {i,k}, scan reads {i,j}
    assign t_raddr = (r_sub == 2'd0) ? {r_i, r_k} : {r_i, r_j};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_sub   <= '0;
            m_out.valid <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (acc) begin
                        if (r_cnt < CntW'(MaxObs)) r_cnt <= r_cnt + 1'b1;
                        else r_ovf <= 1'b1;
                        if (last) begin
                            r_i <= '0;
                            r_j <= '0;
                            r_state <= S_DA;
                        end
                    end
                end
                // advance over all (i,j) pairs; full matrix computed
                S_DA: r_state <= S_DB;
                S_DB: begin
                    r_da    <= d_rdata;
                    r_state <= S_DW;
                end
                S_DW: begin
                    if (r_j == nm1) begin
                        r_j <= '0;
                        if (r_i == nm1) begin
                            r_i <= '0;
                            r_k <= '0;
                            r_j <= '0;
                            r_sub <= '0;
                            r_best <= '0;
                            r_best_med <= '1;
                            r_state <= S_MED;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_state <= S_DA;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_DA;
                    end
                end
                // for each candidate k, count less/leq in row; median is v with
                // less <= half < leq
                S_MED: begin
                    case (r_sub)
                        2'd0: r_sub <= 2'd1;
                        2'd1: begin
                            r_cand <= t_rdata;
                            r_less <= '0;
                            r_leq  <= '0;
                            r_sub  <= 2'd2;
                        end
                        2'd2: r_sub <= 2'd3;
                        default: begin
                            if (t_rdata < r_cand) r_less <= r_less + 1'b1;
                            if (t_rdata <= r_cand) r_leq <= r_leq + 1'b1;
                            if (r_j == nm1) begin
                                r_sub <= 2'd2;
                                r_j   <= '0;
                                r_state <= S_FW;
                            end else begin
                                r_j <= r_j + 1'b1;
                                r_sub <= 2'd2;
                            end
                        end
                    endcase
                end
                S_FW: begin
                    // row i, candidate k scanned
                    if (r_less <= half && r_leq > half) begin
                        if ({1'b0, r_cand} < {1'b0, r_best_med} || r_i == '0) begin
                            r_best_med <= r_cand;
                            r_best <= r_i;
                        end
                        r_k <= '0;
                        if (r_i == nm1) r_state <= S_FETCH;
                        else begin
                            r_i <= r_i + 1'b1;
                            r_sub <= '0;
                            r_state <= S_MED;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_sub <= '0;
                        r_state <= S_MED;
                    end
                end
                S_FETCH: begin
                    r_sub <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!m_out.valid) begin
                        m_out.valid <= 1'b1;
                        m_out.data <= {r_ovf, d_rdata, DistW'(r_best_med),
                                       OutIdxW'(r_best)};
                    end else if (m_out.ready) begin
                        m_out.valid <= 1'b0;
                        r_cnt <= '0;
                        r_ovf <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !s_in.ready) else $error("ready while busy");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(MaxObs)) else $error("count overrun");
    a_out_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> (r_state == S_OUT)) else $error("stray output");
`endif
endmodule

@@ tb/mhds_selection_checker.sv @@
`timescale 1ns / 100ps
// Checker for the median Hamming descriptor selector: watches both channels,
// predicts each selection and compares it. Depends on mhds_pkg and mhds_if.
module mhds_selection_checker
    import mhds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mhds_if      in_ch,
    mhds_if      out_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_sets_seen,
    output int   o_overflow_sets
);
    typedef struct packed {
        logic [OutIdxW-1:0] idx;
        logic [DistW-1:0]   med;
        logic [DescW-1:0]   desc;
        logic               ovf;
    } t_selection;

    localparam int RingDepth = 8;

    logic [DescW-1:0] held_desc [MaxObs];
    int               held_n;
    bit               dropped;
    t_selection       exp_ring [RingDepth];
    int               wr_cnt;
    int               rd_cnt;

    // Pick the first descriptor with the strictly smallest row median.
    function automatic t_selection pick_distinctive(input int n, input bit ovf);
        t_selection sel;
        int         row [MaxObs];
        int         best_med;
        int         v;
        int         j;
        sel.idx  = '0;
        sel.med  = '0;
        sel.desc = held_desc[0];
        sel.ovf  = ovf;
        if (n > 1) begin
            best_med = 10000;
            for (int r = 0; r < n; r++) begin
                // insertion sort of the distance row, self-distance included
                for (int c = 0; c < n; c++) begin
                    v = $countones(held_desc[r] ^ held_desc[c]);
                    j = c;
                    while (j > 0 && row[j-1] > v) begin
                        row[j] = row[j-1];
                        j--;
                    end
                    row[j] = v;
                end
                if (row[(n-1)/2] < best_med) begin
                    best_med = row[(n-1)/2];
                    sel.idx  = r[OutIdxW-1:0];
                    sel.desc = held_desc[r];
                end
            end
            sel.med = best_med[DistW-1:0];
        end
        return sel;
    endfunction

    always @(posedge i_clk) begin
        t_selection exp_sel;
        t_selection got;
        int         errs;
        errs = 0;
        if (!i_rst_n) begin
            held_n          = 0;
            dropped         = 0;
            wr_cnt          = 0;
            rd_cnt          = 0;
            o_fail_count    <= 0;
            o_pending       <= 0;
            o_sets_seen     <= 0;
            o_overflow_sets <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                // store the word, or drop it when the store is full
                if (held_n < MaxObs) begin
                    held_desc[held_n] = in_ch.data[DescW-1:0];
                    held_n            = held_n + 1;
                end else begin
                    dropped = 1;
                end
                if (in_ch.data[DescW]) begin
                    exp_ring[wr_cnt % RingDepth] = pick_distinctive(held_n, dropped);
                    wr_cnt = wr_cnt + 1;
                    o_sets_seen <= o_sets_seen + 1;
                    if (dropped) o_overflow_sets <= o_overflow_sets + 1;
                    held_n  = 0;
                    dropped = 0;
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                got.idx  = out_ch.data[4:0];
                got.med  = out_ch.data[13:5];
                got.desc = out_ch.data[269:14];
                got.ovf  = out_ch.data[270];
                if (wr_cnt == rd_cnt) begin
                    $error("unexpected selection word: index %0d median %0d",
                           got.idx, got.med);
                    errs++;
                end else begin
                    exp_sel = exp_ring[rd_cnt % RingDepth];
                    rd_cnt  = rd_cnt + 1;
                    if (got.idx !== exp_sel.idx) begin
                        $error("best_index: expected %0d, got %0d", exp_sel.idx, got.idx);
                        errs++;
                    end
                    if (got.med !== exp_sel.med) begin
                        $error("best_median: expected %0d, got %0d", exp_sel.med, got.med);
                        errs++;
                    end
                    for (int w = 0; w < 4; w++) begin
                        if (got.desc[w*64 +: 64] !== exp_sel.desc[w*64 +: 64]) begin
                            $error("best_word%0d: expected %h, got %h", w,
                                   exp_sel.desc[w*64 +: 64], got.desc[w*64 +: 64]);
                            errs++;
                        end
                    end
                    if (got.ovf !== exp_sel.ovf) begin
                        $error("overflow: expected %0d, got %0d", exp_sel.ovf, got.ovf);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= wr_cnt - rd_cnt;
        end
    end
endmodule

@@ tb/tb_median_hamming_descriptor_select.sv @@
`timescale 1ns / 100ps
// Top of the testbench for median_hamming_descriptor_select: makes descriptor
// sets and gives the verdict. Depends on mhds_pkg, mhds_if and the checker.
module tb_median_hamming_descriptor_select;
    import mhds_pkg::*;

    localparam int RandomWords = 1200;
    localparam int CalmWords   = 150;      // last stretch runs without idling
    localparam int CycleLimit  = 20000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mhds_if #(.W(DescW + 1))                in_ch ();
    mhds_if #(.W(OutIdxW + DistW + DescW + 1)) out_ch ();

    int  fail_count;
    int  pending;
    int  sets_seen;
    int  overflow_sets;
    int  cycles = 0;
    int  stall_left = 0;
    bit  calm = 0;
    int  words_sent = 0;

    median_hamming_descriptor_select DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch),
        .m_out   (out_ch)
    );

    mhds_selection_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_sets_seen     (sets_seen),
        .o_overflow_sets (overflow_sets)
    );

    always #5 i_clk = ~i_clk;

    // Give up if the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb_median_hamming_descriptor_select NOT OK");
            $finish;
        end
    end

    // Result side: hold ready low in random bursts; no new burst starts in the calm stretch.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 9);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Drive one descriptor word; an optional idle burst comes first.
    task automatic send_desc(input logic [DescW-1:0] d, input bit last);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {last, d};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [DescW-1:0] rand_desc();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Flip up to six random bits of a base descriptor: near copies make
    // close medians and ties.
    function automatic logic [DescW-1:0] near_desc(input logic [DescW-1:0] base);
        logic [DescW-1:0] d;
        int               flips;
        d     = base;
        flips = $urandom_range(0, 6);
        for (int k = 0; k < flips; k++) d[$urandom_range(0, DescW - 1)] ^= 1'b1;
        return d;
    endfunction

    // One set of n words; contents mix random, near copies and extremes.
    task automatic send_set(input int n);
        logic [DescW-1:0] base;
        logic [DescW-1:0] d;
        base = rand_desc();
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0:       d = '0;
                1:       d = '1;
                2, 3:    d = rand_desc();
                default: d = near_desc(base);
            endcase
            send_desc(d, k == n - 1);
        end
    endtask

    // Drop valid, then wait until every expected result is back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int r;
        int n;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: single descriptor, extremes, ties, identical set.
        send_desc('1, 1'b1);
        send_desc('0, 1'b1);
        send_desc('0, 1'b0);
        send_desc('1, 1'b1);                 // equal medians, index 0 wins
        for (int k = 0; k < 3; k++) send_desc({4{64'hA5A5_5A5A_0F0F_F0F0}}, k == 2);
        send_desc('0, 1'b0);
        send_desc({128'd0, {128{1'b1}}}, 1'b0);
        send_desc('1, 1'b0);
        send_desc({{128{1'b1}}, 128'd0}, 1'b1);
        for (int k = 0; k < 5; k++) send_desc(rand_desc(), k == 4);
        drain();                             // hold off until every result is back

        // Random sets: mostly small, some full, a few past capacity.
        while (words_sent < RandomWords) begin
            if (words_sent > RandomWords - CalmWords) calm = 1;
            r = $urandom_range(0, 99);
            if (r < 85)      n = $urandom_range(1, 8);
            else if (r < 95) n = $urandom_range(9, 20);
            else if (r < 98) n = MaxObs;
            else             n = $urandom_range(MaxObs + 1, MaxObs + 4);
            send_set(n);
            if (r == 50) drain();
        end

        drain();
        repeat (100) @(posedge i_clk);
        $display("Sent %0d descriptor words in %0d sets, %0d of them past capacity.",
                 words_sent, sets_seen, overflow_sets);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_median_hamming_descriptor_select OK");
        end else begin
            $display("tb_median_hamming_descriptor_select NOT OK");
        end
        $finish;
    end
endmodule
